// ----- src/simon_key_expansion_core_assert.svh -----
// Assertion helpers for the key schedule checker.
`ifndef SIMON_KEY_EXPANSION_CORE_ASSERT_SVH
`define SIMON_KEY_EXPANSION_CORE_ASSERT_SVH

// Check a condition in the same cycle, outside reset.
`define SKX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key schedule assertion failed");

// Check a condition in the cycle after, outside reset.
`define SKX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key schedule assertion failed");

// Check a condition in the cycle after a reset cycle.
`define SKX_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("key schedule reset assertion failed");

`endif

// ----- src/simon_kx_pkg.sv -----
`timescale 1ns / 1ps

package simon_kx_pkg;

  localparam int KEY_BITS      = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int Z_PERIOD      = 62;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    REG_KEY_WORDS   = 2'd0,
    REG_Z_SELECT    = 2'd1,
    REG_ROUND_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                req_type;
    logic [KEY_BITS-1:0] key_word;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] round_key;
    logic [6:0]          round_number;
    logic                last_round;
    logic                status;
  } out_item_t;

  typedef logic [0:Z_PERIOD-1] zseq_t;

  localparam zseq_t ZSEQ [5] = '{
    62'b11111010001001010110000111001101111101000100101011000011100110,
    62'b10001110111110010011000010110101000111011111001001100001011010,
    62'b10101111011100000011010010011000101000010001111110010110110011,
    62'b11011011101011000110010111100000010010001010011100110100001111,
    62'b11010001111001101011011000100000010111000011001010010011101111
  };

endpackage

// ----- src/simon_kx_round.sv -----
`timescale 1ns / 1ps

module simon_kx_round import simon_kx_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [3:0][WORD_BITS-1:0] window,
  input  logic [2:0]                key_words,
  input  logic [2:0]                z_sel,
  input  logic [5:0]                z_pos,
  output logic [WORD_BITS-1:0]      next_word
);

  localparam logic [WORD_BITS-1:0] ROUND_CONST = ~WORD_BITS'(3);

  logic [WORD_BITS-1:0] last_w;
  logic [WORD_BITS-1:0] t0;
  logic [WORD_BITS-1:0] t1;
  logic                 z_bit;

  always_comb begin
    case (key_words)
      3'd2:    last_w = window[1];
      3'd3:    last_w = window[2];
      default: last_w = window[3];
    endcase
    t0 = {last_w[2:0], last_w[WORD_BITS-1:3]};
    if (key_words == 3'd4) begin
      t0 = t0 ^ window[1];
    end
    t1        = t0 ^ {t0[0], t0[WORD_BITS-1:1]};
    z_bit     = ZSEQ[z_sel][z_pos];
    next_word = ROUND_CONST ^ window[0] ^ t1 ^ WORD_BITS'(z_bit);
  end

endmodule

// ----- src/simon_key_expansion_core.sv -----
`timescale 1ns / 1ps
// Simon round-key generator, one round key per transaction.
// Input channel (in_valid, in_stall, in_data): a load transaction carries one
// master key word, k0 first, and is echoed as round key 0 .. m-1; an advance
// transaction yields the next round key. A load after a complete key starts
// a new key. An advance before the key is complete or after the last round
// returns status 1 with all other fields zero and changes nothing.
// Output channel (out_valid, out_stall, out_data): one result per transaction.
// Each result is registered in the output entry, or in the skid entry while
// the receiver stalls; throughput is one transaction per cycle while out_stall
// is low, set by the single registered round pass and two-entry output buffer.
// When the receiver stalls, the output holds and one more transaction is
// taken into the skid entry; in_stall then rises until the receiver takes
// the held result.
// Configuration (APB, pready always high): key_words at 0x0, z_select at
// 0x4, round_count at 0x8; write only while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults (4, 4, 72),
// clears the key window and counters and empties the output buffer.

module simon_key_expansion_core import simon_kx_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] key_words_r;
  logic [2:0] z_select_r;
  logic [6:0] round_count_r;

  logic [3:0][WORD_BITS-1:0] win_r, win_nxt;
  logic [6:0]                rounds_r, rounds_nxt;
  logic [5:0]                zpos_r, zpos_nxt;

  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  logic [2:0]           m_eff;
  logic [2:0]           z_eff;
  logic                 accept;
  logic                 restart;
  logic                 can_adv;
  logic [6:0]           idx;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] round_word;
  out_item_t            res;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_words_r   <= 3'd4;
      z_select_r    <= 3'd4;
      round_count_r <= 7'd72;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_KEY_WORDS:   key_words_r   <= pwdata[2:0];
        REG_Z_SELECT:    z_select_r    <= pwdata[2:0];
        REG_ROUND_COUNT: round_count_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KEY_WORDS:   prdata = 32'(key_words_r);
      REG_Z_SELECT:    prdata = 32'(z_select_r);
      REG_ROUND_COUNT: prdata = 32'(round_count_r);
      default:         prdata = 32'd0;
    endcase
  end

  assign m_eff = (key_words_r < 3'd2) ? 3'd2 : ((key_words_r > 3'd4) ? 3'd4 : key_words_r);
  assign z_eff = (z_select_r > 3'd4) ? 3'd4 : z_select_r;

  simon_kx_round #(
    .WORD_BITS(WORD_BITS)
  ) u_round (
    .window    (win_r),
    .key_words (m_eff),
    .z_sel     (z_eff),
    .z_pos     (zpos_r),
    .next_word (round_word)
  );

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign restart  = rounds_r >= {4'd0, m_eff};
  assign can_adv  = restart && (rounds_r < round_count_r);

  always_comb begin
    win_nxt    = win_r;
    rounds_nxt = rounds_r;
    zpos_nxt   = zpos_r;
    idx        = rounds_r;
    word       = round_word;
    res        = '0;
    if (in_data.req_type == REQ_LOAD) begin
      idx  = restart ? 7'd0 : rounds_r;
      word = in_data.key_word[WORD_BITS-1:0];
      win_nxt[idx[1:0]] = word;
      rounds_nxt = idx + 7'd1;
      if (restart) begin
        zpos_nxt = 6'd0;
      end
      res.round_key    = KEY_BITS'(word);
      res.round_number = idx;
      res.last_round   = ({1'b0, idx} + 8'd1) == {1'b0, round_count_r};
    end else if (can_adv) begin
      win_nxt[0] = win_r[1];
      case (m_eff)
        3'd2: begin
          win_nxt[1] = word;
        end
        3'd3: begin
          win_nxt[1] = win_r[2];
          win_nxt[2] = word;
        end
        default: begin
          win_nxt[1] = win_r[2];
          win_nxt[2] = win_r[3];
          win_nxt[3] = word;
        end
      endcase
      zpos_nxt   = (zpos_r == 6'(Z_PERIOD - 1)) ? 6'd0 : zpos_r + 6'd1;
      rounds_nxt = rounds_r + 7'd1;
      res.round_key    = KEY_BITS'(word);
      res.round_number = idx;
      res.last_round   = ({1'b0, idx} + 8'd1) == {1'b0, round_count_r};
    end else begin
      res.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      rounds_r <= 7'd0;
      zpos_r   <= 6'd0;
    end else if (accept) begin
      win_r    <= win_nxt;
      rounds_r <= rounds_nxt;
      zpos_r   <= zpos_nxt;
    end
  end

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/simon_kx_checker.sv -----
`timescale 1ns / 1ps
`include "simon_key_expansion_core_assert.svh"

module simon_kx_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  `SKX_ASSERT_RESET(a_reset_empty, !out_valid && !in_stall)
  `SKX_ASSERT_NOW(a_stall_needs_output, in_stall, out_valid)
  `SKX_ASSERT_NEXT(a_accept_shows_result, in_valid && !in_stall, out_valid)
  `SKX_ASSERT_NEXT(a_skid_drains, in_stall && !out_stall, !in_stall)

endmodule

bind simon_key_expansion_core simon_kx_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
